[rtl/glu_pkg.sv]
// ----------------------------------------------------------------------------
// glu_pkg: shared types and constants for the gcd / lcm unit
// Holds the default data width, the operation codes and the control state
// type used by the controller.
// ----------------------------------------------------------------------------
package glu_pkg;

    localparam int DATA_WIDTH = 32;

    typedef enum logic {
        OP_GCD = 1'b0,
        OP_LCM = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EUCLID,
        ST_DIV,
        ST_GCD_DONE,
        ST_QDIV,
        ST_QDIV_RUN,
        ST_MUL,
        ST_MUL_RUN,
        ST_LCM_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture operands and magnitudes
        logic div_start;  // start a remainder step x % y
        logic qdiv_start; // start the quotient step ma / g
        logic mul_start;  // start the serial multiply mq * mb
        logic finish_gcd;
        logic finish_lcm;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic op_lcm;
        logic y_zero;
        logic x_zero;
        logic any_zero;   // ma or mb zero
        logic div_busy;
        logic mul_busy;
    } t_status;

endpackage

[rtl/gcd_lcm_unit.sv]
// ----------------------------------------------------------------------------
// gcd_lcm_unit: signed gcd or lcm, one answer per command
//
//  channel  | ports                                      | transfer
//  command  | start, i_operation, i_operand_a/_b          | start && !busy
//  result   | o_done, o_result, o_overflow               | o_done, one cycle
//
// Each euclid remainder step is one pass of the shared serial divider; lcm
// adds one divide and a shift-add multiply. Zero operands skip the euclid
// loop. Reset is synchronous and only clears control state. The receiver
// cannot stall: the result is shown for one cycle with o_done.
// ----------------------------------------------------------------------------
module gcd_lcm_unit #(
    parameter int DATA_WIDTH = glu_pkg::DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_operation,
    input  logic signed [DATA_WIDTH-1:0] i_operand_a,
    input  logic signed [DATA_WIDTH-1:0] i_operand_b,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_result,
    output logic                         o_overflow
);
    glu_pkg::t_cmd    cmd;
    glu_pkg::t_status status;

    glu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    glu_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_operation (i_operation),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_result    (o_result),
        .o_overflow  (o_overflow)
    );
endmodule

[rtl/glu_datapath.sv]
// ----------------------------------------------------------------------------
// glu_datapath: operand registers, serial divider and serial multiplier
// One restoring divider is shared by the euclid remainder steps and the
// lcm quotient; a shift-add multiplier forms the lcm magnitude.
// ----------------------------------------------------------------------------
module glu_datapath #(
    parameter int DATA_WIDTH = glu_pkg::DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_operation,
    input  logic signed [DATA_WIDTH-1:0] i_operand_a,
    input  logic signed [DATA_WIDTH-1:0] i_operand_b,
    input  glu_pkg::t_cmd                i_cmd,
    output glu_pkg::t_status             o_status,
    output logic signed [DATA_WIDTH-1:0] o_result,
    output logic                         o_overflow
);
    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam logic [W-1:0] SIGN = {1'b1, {(W-1){1'b0}}};

    logic         r_op;
    logic         r_na, r_nb;
    logic [W-1:0] r_ma, r_mb;
    logic [W-1:0] r_x, r_y;

    // divider
    logic [W-1:0]  r_dq;     // dividend shifting out, quotient shifting in
    logic [W-1:0]  r_drem;
    logic [W-1:0]  r_dden;
    logic [CW-1:0] r_dcnt;
    logic          r_dbusy;
    logic          r_dsel;   // 0 euclid step, 1 quotient step

    // multiplier
    logic [2*W-1:0] r_prod;
    logic [W-1:0]   r_mcand;
    logic [W-1:0]   r_mplier;
    logic [CW-1:0]  r_mcnt;
    logic           r_mbusy;

    logic [W-1:0] r_res;
    logic         r_ovf;

    logic [W:0]   rem_sh;
    logic [W:0]   rem_sub;
    logic [W-1:0] mag_a, mag_b;
    logic [2*W-1:0] limit;
    logic [W-1:0] gcd_val;

    assign mag_a   = i_operand_a[W-1] ? (~i_operand_a + 1'b1) : i_operand_a;
    assign mag_b   = i_operand_b[W-1] ? (~i_operand_b + 1'b1) : i_operand_b;
    assign rem_sh  = {r_drem, r_dq[W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dden};
    assign limit   = (r_na != r_nb) ? {{W{1'b0}}, SIGN} : {{W{1'b0}}, SIGN - 1'b1};
    // a zero x means the gcd is the other magnitude, left in y
    assign gcd_val = (r_x == '0) ? r_y : r_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_mbusy <= 1'b0;
        end else begin
            if (i_cmd.div_start || i_cmd.qdiv_start) begin
                r_dbusy <= 1'b1;
            end else if (r_dbusy && r_dcnt == CW'(1)) begin
                r_dbusy <= 1'b0;
            end
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
            end else if (r_mbusy && r_mcnt == CW'(1)) begin
                r_mbusy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_operation;
            r_na <= i_operand_a[W-1];
            r_nb <= i_operand_b[W-1];
            r_ma <= mag_a;
            r_mb <= mag_b;
            r_x  <= mag_a;
            r_y  <= mag_b;
        end
        if (i_cmd.div_start || i_cmd.qdiv_start) begin
            r_dq   <= i_cmd.qdiv_start ? r_ma : r_x;
            // x holds the gcd when the quotient step starts
            r_dden <= i_cmd.qdiv_start ? r_x : r_y;
            r_drem <= '0;
            r_dcnt <= CW'(W);
            r_dsel <= i_cmd.qdiv_start;
        end else if (r_dbusy) begin
            if (!rem_sub[W]) begin
                r_drem <= rem_sub[W-1:0];
                r_dq   <= {r_dq[W-2:0], 1'b1};
            end else begin
                r_drem <= rem_sh[W-1:0];
                r_dq   <= {r_dq[W-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt - 1'b1;
            // euclid step retires: x <= y, y <= remainder
            if (r_dcnt == CW'(1) && !r_dsel) begin
                r_x <= r_y;
                r_y <= rem_sub[W] ? rem_sh[W-1:0] : rem_sub[W-1:0];
            end
        end
        if (i_cmd.mul_start) begin
            r_prod   <= '0;
            r_mcand  <= r_dq;    // quotient ma / g
            r_mplier <= r_mb;
            r_mcnt   <= CW'(W);
        end else if (r_mbusy) begin
            if (r_mplier[0]) begin
                r_prod <= r_prod + ({{W{1'b0}}, r_mcand} << (W - int'(r_mcnt)));
            end
            r_mplier <= r_mplier >> 1;
            r_mcnt   <= r_mcnt - 1'b1;
        end
        if (i_cmd.finish_gcd) begin
            // a gcd magnitude of 2^(W-1) does not fit
            r_ovf <= gcd_val[W-1];
            r_res <= gcd_val[W-1] ? '0 : gcd_val;
        end
        if (i_cmd.finish_lcm) begin
            if (r_ma == '0 || r_mb == '0) begin
                r_ovf <= 1'b0;
                r_res <= '0;
            end else if (r_prod > limit) begin
                r_ovf <= 1'b1;
                r_res <= '0;
            end else begin
                r_ovf <= 1'b0;
                r_res <= (r_na != r_nb) ? (~r_prod[W-1:0] + 1'b1) : r_prod[W-1:0];
            end
        end
    end

    assign o_status.op_lcm   = r_op;
    assign o_status.y_zero   = (r_y == '0);
    assign o_status.x_zero   = (r_x == '0);
    assign o_status.any_zero = (r_ma == '0) || (r_mb == '0);
    assign o_status.div_busy = r_dbusy;
    assign o_status.mul_busy = r_mbusy;
    assign o_result   = r_res;
    assign o_overflow = r_ovf;

endmodule

[rtl/glu_ctrl.sv]
// ----------------------------------------------------------------------------
// glu_ctrl: command sequencer for the gcd / lcm unit
// Steps the euclid loop, the quotient divide and the multiply, and raises
// the done strobe for one cycle.
// ----------------------------------------------------------------------------
module glu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  glu_pkg::t_status i_status,
    output glu_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_done
);
    glu_pkg::t_state r_state, n_state;
    logic            r_done, n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= glu_pkg::ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            glu_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = glu_pkg::ST_LOAD;
                end
            end
            glu_pkg::ST_LOAD: begin
                // a zero operand skips the loop: for gcd x or y is already the answer, lcm is zero
                if (i_status.op_lcm) begin
                    if (i_status.any_zero) begin
                        n_state = glu_pkg::ST_LCM_DONE;
                    end else begin
                        n_state = glu_pkg::ST_EUCLID;
                    end
                end else if (i_status.x_zero || i_status.y_zero) begin
                    n_state = glu_pkg::ST_GCD_DONE;
                end else begin
                    n_state = glu_pkg::ST_EUCLID;
                end
            end
            glu_pkg::ST_EUCLID: begin
                if (i_status.y_zero) begin
                    n_state = i_status.op_lcm ? glu_pkg::ST_QDIV : glu_pkg::ST_GCD_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = glu_pkg::ST_DIV;
                end
            end
            glu_pkg::ST_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = glu_pkg::ST_EUCLID;
                end
            end
            glu_pkg::ST_GCD_DONE: begin
                // the gcd sits in x, or in y when x is zero; handled by finish
                o_cmd.finish_gcd = 1'b1;
                n_done           = 1'b1;
                n_state          = glu_pkg::ST_IDLE;
            end
            glu_pkg::ST_QDIV: begin
                o_cmd.qdiv_start = 1'b1;
                n_state          = glu_pkg::ST_QDIV_RUN;
            end
            glu_pkg::ST_QDIV_RUN: begin
                if (!i_status.div_busy) begin
                    n_state = glu_pkg::ST_MUL;
                end
            end
            glu_pkg::ST_MUL: begin
                o_cmd.mul_start = 1'b1;
                n_state         = glu_pkg::ST_MUL_RUN;
            end
            glu_pkg::ST_MUL_RUN: begin
                if (!i_status.mul_busy) begin
                    n_state = glu_pkg::ST_LCM_DONE;
                end
            end
            glu_pkg::ST_LCM_DONE: begin
                o_cmd.finish_lcm = 1'b1;
                n_done           = 1'b1;
                n_state          = glu_pkg::ST_IDLE;
            end
            default: begin
                n_state = glu_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != glu_pkg::ST_IDLE);
    assign o_done = r_done;

    no_start_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != glu_pkg::ST_IDLE) |-> !o_cmd.load)
        else $error("load issued while busy");
    done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done strobe longer than one cycle");
    finish_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.finish_gcd || o_cmd.finish_lcm) |=> o_done)
        else $error("finish not followed by done");
endmodule
